/* src/qecf_pkg.sv */
package qecf_pkg;

  // Element geometry.
  localparam int ElementBytes = 'h1000;
  localparam int ElemWords    = ElementBytes / 8;
  localparam int CountW       = $clog2(ElemWords);

  // Payload length folding: length = LenMin + raw mod LenSpan.
  localparam int LenMin    = 32;
  localparam int LenMax    = 4048;
  localparam int LenSpan   = LenMax - LenMin + 1;
  localparam int HdrBytes  = 48;
  localparam int LimitBias = HdrBytes + 7;
  localparam int LenW      = 12;
  localparam int LimitW    = 10;
  localparam int RemW      = 13;

  // Smallest coverage in words; positions below it are always counted.
  localparam int MinWords = (HdrBytes + LenMin + 7) / 8;

  // Exact reciprocal for raw / LenSpan over all 32-bit raw values.
  localparam int          RecipShift = 44;
  localparam logic [32:0] RecipMul   = 33'd4379433917;
  localparam int          QuoW       = 21;

  localparam logic [CountW-1:0] CksumWord  = CountW'(4);
  localparam logic [CountW-1:0] LengthWord = CountW'(7);

  typedef struct packed {
    logic [63:0] data_word;
    logic        last_word;
  } qecf_in_t;

  typedef struct packed {
    logic [LenW-1:0] payload_length;
    logic [31:0]     checksum;
  } qecf_out_t;

  typedef struct packed {
    logic              valid;
    logic [LenW-1:0]   length;
    logic [LimitW-1:0] limit;
  } qecf_fold_t;

endpackage

/* src/queue_element_checksum_fixup.sv */
// A result is valid in the cycle after the accepted request carrying the last
// word; a last word 7 or 8 first waits for the length fold and a free output.
// Throughput: one word per cycle; when an element ends on word 7 or 8, input is
// stalled until the two-stage length fold (reciprocal multiply, then remainder)
// drains, and a last word also waits while a stalled result holds the output.
// Reset: asynchronous, active low; clears the word count, running XOR, held
// length and coverage, the fold pipeline and the result valid flag.
module queue_element_checksum_fixup import qecf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  qecf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output qecf_out_t out_data_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [63:0]       xor_q, xor_d;
  logic [LimitW-1:0] limit_q, limit_d;
  logic [LenW-1:0]   flen_q, flen_d;
  logic              fin_q, fin_d;
  logic              out_valid_q, out_valid_d;
  qecf_out_t         out_q, out_d;

  logic       in_acc, out_free, start, counted, emit, s1_busy;
  logic [63:0] word_m, word_x, fold_x;
  qecf_fold_t fold;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign start    = in_acc && (count_q == LengthWord);

  qecf_len_fold u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .raw_i     (in_data_i.data_word[31:0]),
    .s1_busy_o (s1_busy),
    .fold_o    (fold)
  );

  // The checksum slot counts as zero; the length slot gets the folded length
  // later, when the fold pipeline delivers it.
  always_comb begin
    word_m = in_data_i.data_word;
    if (count_q == CksumWord || count_q == LengthWord) begin
      word_m[31:0] = 32'd0;
    end
  end

  // Words below the smallest coverage are counted before the new limit lands.
  assign counted = (count_q < CountW'(MinWords)) || ({1'b0, count_q} < limit_q);
  assign word_x  = (in_acc && counted) ? word_m : 64'd0;
  assign fold_x  = fold.valid ? {52'd0, fold.length} : 64'd0;

  assign emit = (in_acc && in_data_i.last_word && !start && !s1_busy) ||
                (fin_q && !s1_busy && out_free);

  always_comb begin
    xor_d   = xor_q ^ word_x ^ fold_x;
    limit_d = fold.valid ? fold.limit : limit_q;
    flen_d  = fold.valid ? fold.length : flen_q;
    count_d = in_acc ? count_q + 1'b1 : count_q;
    fin_d   = fin_q || (in_acc && in_data_i.last_word && (start || s1_busy));

    out_d.payload_length = flen_d;
    out_d.checksum       = xor_d[63:32] ^ xor_d[31:0];

    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      xor_q       <= '0;
      limit_q     <= '0;
      flen_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        count_q <= '0;
        xor_q   <= '0;
        limit_q <= '0;
        flen_q  <= '0;
        fin_q   <= 1'b0;
      end else begin
        count_q <= count_d;
        xor_q   <= xor_d;
        limit_q <= limit_d;
        flen_q  <= flen_d;
        fin_q   <= fin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  // A last word waits while a stalled result holds the output, and a pending
  // last word holds off all new requests until its result is out.
  assign in_stall_o  = fin_q || (in_data_i.last_word && !out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fold_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold.valid |-> $past(start, 2))
    else $error("fold result without a length word two cycles earlier");

  a_limit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (count_q >= CountW'(MinWords)) |-> !s1_busy && !fold.valid)
    else $error("coverage word accepted while the length fold is in flight");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.payload_length != '0) |->
      (out_data_o.payload_length >= LenW'(LenMin)) &&
      (out_data_o.payload_length <= LenW'(LenMax)))
    else $error("folded payload length out of range");

endmodule

/* src/qecf_len_fold.sv */
module qecf_len_fold import qecf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [31:0] raw_i,
  output logic       s1_busy_o,
  output qecf_fold_t fold_o
);

  logic            v1_q, v2_q;
  logic [31:0]     raw1_q, raw2_q;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [64:0]     prod;
  logic [31:0]     rem_full;
  logic [RemW-1:0] rem, rem_adj;
  logic [LenW-1:0] length;
  logic [RemW-1:0] limit_sum;

  // Stage one: quotient by multiplication with the reciprocal.
  assign prod  = 65'(raw1_q) * 65'(RecipMul);
  assign quo_d = prod[RecipShift +: QuoW];

  // Stage two: remainder, one guard correction, then length and coverage.
  assign rem_full  = raw2_q - 32'(quo_q) * 32'(LenSpan);
  assign rem       = rem_full[RemW-1:0];
  assign rem_adj   = (rem >= RemW'(LenSpan)) ? rem - RemW'(LenSpan) : rem;
  assign length    = LenW'(rem_adj) + LenW'(LenMin);
  assign limit_sum = RemW'(length) + RemW'(LimitBias);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      raw1_q <= raw_i;
    end
    if (v1_q) begin
      raw2_q <= raw1_q;
      quo_q  <= quo_d;
    end
  end

  assign s1_busy_o     = v1_q;
  assign fold_o.valid  = v2_q;
  assign fold_o.length = length;
  assign fold_o.limit  = LimitW'(limit_sum >> 3);

endmodule
